// ----- sv/dwpid_pkg.sv -----
`timescale 1ns / 1ps
// Package for the dual-wheel PID speed controller.
// Holds the item, configuration and state types and the widths used by the modules.
package dwpid_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] CFG_PROP_GAIN    = 3'd0;
    localparam logic [2:0] CFG_INTEG_GAIN   = 3'd1;
    localparam logic [2:0] CFG_DERIV_GAIN   = 3'd2;
    localparam logic [2:0] CFG_STEP_TIME    = 3'd3;
    localparam logic [2:0] CFG_INVERSE_STEP = 3'd4;
    localparam logic [2:0] CFG_DRIVE_LIMIT  = 3'd5;
    localparam logic [2:0] CFG_TICK_SCALE   = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register values after reset.
    localparam logic [31:0] RST_PROP_GAIN    = 32'd82208;
    localparam logic [31:0] RST_INTEG_GAIN   = 32'd198345281;
    localparam logic [31:0] RST_DERIV_GAIN   = 32'd0;
    localparam logic [23:0] RST_STEP_TIME    = 24'd167772;
    localparam logic [15:0] RST_INVERSE_STEP = 16'd100;
    localparam logic [14:0] RST_DRIVE_LIMIT  = 15'd1000;
    localparam logic [30:0] RST_TICK_SCALE   = 31'd5487588;

    // Shared multiplier: signed 33 x 32 bits.
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int ACC_W   = 60;
    localparam int INTEG_W = 48;
    localparam int DERIV_W = 50;

    typedef struct packed {
        logic signed [23:0] ticks_left;
        logic signed [23:0] ticks_right;
        logic signed [31:0] target_left;
        logic signed [31:0] target_right;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] drive_left;
        logic signed [15:0] drive_right;
        logic [14:0]        pwm_left;
        logic [14:0]        pwm_right;
        logic               dir_left;
        logic               dir_right;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] prop_gain;
        logic signed [31:0] integ_gain;
        logic signed [31:0] deriv_gain;
        logic [23:0]        step_time;
        logic [15:0]        inverse_step;
        logic [14:0]        drive_limit;
        logic [30:0]        tick_scale;
    } t_cfg;

    // Each step names the product issued to the multiplier in that cycle and
    // the write-back of the product issued in the step before.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPEED,
        ST_ERR,
        ST_INC,
        ST_DIFF,
        ST_PLO,
        ST_PHI,
        ST_ILO,
        ST_IHI,
        ST_DLO,
        ST_DHI,
        ST_LAST,
        ST_CLAMP,
        ST_DONE
    } t_state;

endpackage

// ----- sv/dwpid_mul.sv -----
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Depends on dwpid_pkg for the operand widths.
module dwpid_mul import dwpid_pkg::*; (
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_p
);

    logic signed [MUL_P_W-1:0] r_p;
    logic signed [MUL_P_W-1:0] n_p;

    assign n_p = MUL_P_W'(i_a) * MUL_P_W'(i_b);

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

// ----- sv/dwpid_core.sv -----
`timescale 1ns / 1ps
// Sequencer and datapath of the PID controller: runs both wheels in turn
// through the shared multiplier. Depends on dwpid_pkg and dwpid_mul.
module dwpid_core import dwpid_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_start,
    input  t_in_item  i_item,
    input  logic      i_out_free,
    output logic      o_busy,
    output logic      o_res_valid,
    output t_out_item o_res
);

    t_state r_state, n_state;
    logic   r_wheel;
    t_in_item r_item;

    logic signed [31:0]        r_err;
    logic signed [DERIV_W-1:0] r_deriv;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [INTEG_W-1:0] r_integ [2];
    logic signed [31:0]        r_last [2];
    logic [14:0]               r_mag [2];
    logic                      r_neg [2];

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;

    logic signed [23:0]        sel_ticks;
    logic signed [31:0]        sel_target;
    logic signed [INTEG_W-1:0] sel_integ;
    logic signed [31:0]        sel_last;

    logic signed [47:0]        err_wide;
    logic signed [31:0]        err_sat;
    logic signed [31:0]        inc;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integ_sat;
    logic signed [ACC_W-1:0]   term_lo;
    logic signed [ACC_W-1:0]   term_hi;
    logic signed [ACC_W-1:0]   lim;
    logic signed [ACC_W-1:0]   neg_lim;
    logic signed [ACC_W-1:0]   v_cl;
    logic [31:0]               v_mag;
    logic [14:0]               mag_l, mag_r;

    dwpid_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign sel_ticks  = r_wheel ? r_item.ticks_right  : r_item.ticks_left;
    assign sel_target = r_wheel ? r_item.target_right : r_item.target_left;
    assign sel_integ  = r_integ[r_wheel];
    assign sel_last   = r_last[r_wheel];

    // Operand selection for the product issued in the current step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_SPEED: begin
                mul_a = {{9{sel_ticks[23]}}, sel_ticks};
                mul_b = {1'b0, i_cfg.tick_scale};
            end
            ST_INC: begin
                mul_a = {r_err[31], r_err};
                mul_b = {8'b0, i_cfg.step_time};
            end
            ST_DIFF: begin
                mul_a = {r_err[31], r_err} - {sel_last[31], sel_last};
                mul_b = {16'b0, i_cfg.inverse_step};
            end
            ST_PLO: begin
                mul_a = {9'b0, r_err[23:0]};
                mul_b = i_cfg.prop_gain;
            end
            ST_PHI: begin
                mul_a = {{25{r_err[31]}}, r_err[31:24]};
                mul_b = i_cfg.prop_gain;
            end
            ST_ILO: begin
                mul_a = {9'b0, sel_integ[23:0]};
                mul_b = i_cfg.integ_gain;
            end
            ST_IHI: begin
                mul_a = {{9{sel_integ[INTEG_W-1]}}, sel_integ[INTEG_W-1:24]};
                mul_b = i_cfg.integ_gain;
            end
            ST_DLO: begin
                mul_a = {9'b0, r_deriv[23:0]};
                mul_b = i_cfg.deriv_gain;
            end
            ST_DHI: begin
                mul_a = {{7{r_deriv[DERIV_W-1]}}, r_deriv[DERIV_W-1:24]};
                mul_b = i_cfg.deriv_gain;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Error: target minus scaled speed, saturated to 32 bits.
    assign err_wide = {{16{sel_target[31]}}, sel_target} - prod[55:8];
    always_comb begin
        if (!err_wide[47] && (|err_wide[46:31])) begin
            err_sat = 32'sh7FFF_FFFF;
        end else if (err_wide[47] && !(&err_wide[46:31])) begin
            err_sat = 32'sh8000_0000;
        end else begin
            err_sat = err_wide[31:0];
        end
    end

    // Integral update, saturated to 48 bits.
    assign inc       = prod[55:24];
    assign integ_sum = {sel_integ[INTEG_W-1], sel_integ} + {{17{inc[31]}}, inc};
    always_comb begin
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            integ_sat = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                           : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            integ_sat = integ_sum[INTEG_W-1:0];
        end
    end

    // Each gain product is split: the low 24 bits of the operand give a term
    // that is floored by 2^24, the high part a term that needs no shift.
    assign term_lo = {{(ACC_W-41){prod[MUL_P_W-1]}}, prod[MUL_P_W-1:24]};
    assign term_hi = prod[ACC_W-1:0];

    assign lim     = {{(ACC_W-31){1'b0}}, i_cfg.drive_limit, 16'b0};
    assign neg_lim = '0 - lim;
    always_comb begin
        if (r_acc > lim) begin
            v_cl = lim;
        end else if (r_acc < neg_lim) begin
            v_cl = neg_lim;
        end else begin
            v_cl = r_acc;
        end
    end
    assign v_mag = v_cl[31] ? (32'd0 - v_cl[31:0]) : v_cl[31:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_start) n_state = ST_SPEED;
            ST_SPEED: n_state = ST_ERR;
            ST_ERR:   n_state = ST_INC;
            ST_INC:   n_state = ST_DIFF;
            ST_DIFF:  n_state = ST_PLO;
            ST_PLO:   n_state = ST_PHI;
            ST_PHI:   n_state = ST_ILO;
            ST_ILO:   n_state = ST_IHI;
            ST_IHI:   n_state = ST_DLO;
            ST_DLO:   n_state = ST_DHI;
            ST_DHI:   n_state = ST_LAST;
            ST_LAST:  n_state = ST_CLAMP;
            ST_CLAMP: n_state = r_wheel ? ST_DONE : ST_SPEED;
            ST_DONE:  if (i_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control and kept state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel    <= 1'b0;
            r_integ[0] <= '0;
            r_integ[1] <= '0;
            r_last[0]  <= '0;
            r_last[1]  <= '0;
        end else begin
            if (r_state == ST_IDLE && i_start) begin
                r_wheel <= 1'b0;
            end else if (r_state == ST_CLAMP) begin
                r_wheel <= ~r_wheel;
            end
            if (r_state == ST_DIFF) begin
                r_integ[r_wheel] <= integ_sat;
            end
            if (r_state == ST_PLO) begin
                r_last[r_wheel] <= r_err;
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_item <= i_item;
        end
        unique case (r_state)
            ST_ERR:   r_err   <= err_sat;
            ST_PLO:   r_deriv <= prod[DERIV_W-1:0];
            ST_PHI:   r_acc   <= term_lo;
            ST_ILO:   r_acc   <= r_acc + term_hi;
            ST_IHI:   r_acc   <= r_acc + term_lo;
            ST_DLO:   r_acc   <= r_acc + term_hi;
            ST_DHI:   r_acc   <= r_acc + term_lo;
            ST_LAST:  r_acc   <= r_acc + term_hi;
            ST_CLAMP: begin
                r_mag[r_wheel] <= v_mag[30:16];
                r_neg[r_wheel] <= v_cl[31];
            end
            default: begin
            end
        endcase
    end

    assign mag_l = r_mag[0];
    assign mag_r = r_mag[1];

    always_comb begin
        o_res.drive_left  = r_neg[0] ? (16'sd0 - {1'b0, mag_l}) : {1'b0, mag_l};
        o_res.drive_right = r_neg[1] ? (16'sd0 - {1'b0, mag_r}) : {1'b0, mag_r};
        o_res.pwm_left    = mag_l;
        o_res.pwm_right   = mag_r;
        o_res.dir_left    = ~r_neg[0];
        o_res.dir_right   = r_neg[1];
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);

endmodule

// ----- sv/dual_wheel_pid_speed_control.sv -----
`timescale 1ns / 1ps
// Dual-wheel PID speed controller, top level.
// Input channel: one item per control tick carries the encoder tick counts
// and the Q16.16 target speeds of both wheels. It is accepted when
// i_in_valid is high and o_in_stall is low. Output channel: one item with
// the clamped drive, PWM magnitude and direction bit of each wheel, taken
// when o_out_valid is high and i_out_stall is low.
// An item passes through twelve steps per wheel on the single shared
// multiplier (nine products each, plus error, clamp and drain steps),
// and one to hand over. A new item is accepted in the cycle after the
// result is loaded into the output register, so items do not overlap.
// o_in_stall is high while an item is being worked on or waits to hand over.
// When the receiver stalls, the finished result stays in the output
// register; a following item may be accepted and worked on, and waits at
// its end until the output register is free.
// Synchronous reset (i_rst_n low) clears the integrals and last errors of
// both wheels, empties the output register and reloads the configuration
// registers with their defaults. The user must see that configuration is
// written only while idle; the block itself does not enforce it.
module dual_wheel_pid_speed_control import dwpid_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    t_out_item r_out;
    logic      r_out_valid;

    logic      core_busy;
    logic      res_valid;
    t_out_item res;
    logic      out_free;
    logic      in_accept;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign in_accept = i_in_valid && !core_busy;

    dwpid_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_start     (in_accept),
        .i_item      (i_in_data),
        .i_out_free  (out_free),
        .o_busy      (core_busy),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain    <= RST_PROP_GAIN;
            r_cfg.integ_gain   <= RST_INTEG_GAIN;
            r_cfg.deriv_gain   <= RST_DERIV_GAIN;
            r_cfg.step_time    <= RST_STEP_TIME;
            r_cfg.inverse_step <= RST_INVERSE_STEP;
            r_cfg.drive_limit  <= RST_DRIVE_LIMIT;
            r_cfg.tick_scale   <= RST_TICK_SCALE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PROP_GAIN:    r_cfg.prop_gain    <= i_cfg_data;
                CFG_INTEG_GAIN:   r_cfg.integ_gain   <= i_cfg_data;
                CFG_DERIV_GAIN:   r_cfg.deriv_gain   <= i_cfg_data;
                CFG_STEP_TIME:    r_cfg.step_time    <= i_cfg_data[23:0];
                CFG_INVERSE_STEP: r_cfg.inverse_step <= i_cfg_data[15:0];
                CFG_DRIVE_LIMIT:  r_cfg.drive_limit  <= i_cfg_data[14:0];
                CFG_TICK_SCALE:   r_cfg.tick_scale   <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && out_free) begin
            r_out <= res;
        end
    end

    assign o_in_stall  = core_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
